### rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

   localparam int OperandWidth = 16;
   localparam int ProdWidth    = 2 * OperandWidth;
   localparam int MagWidth     = ProdWidth + 1;
   localparam int CntWidth     = $clog2(MagWidth + 1);

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_LT  = 3'd4,
      OP_EQ  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_SUM,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic prod;
      logic sum;
      logic gcd_step;
      logic div_start;
      logic div_step;
      logic div_den;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic early;
      logic gcd_done;
      logic div_last;
   } sts_type;

endpackage

### rtl/rau_datapath.sv
// Datapath: cross products, binary GCD by subtraction and shift, restoring division.
module rau_datapath
   import rau_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output sts_type                        sts,
   input  logic [2:0]                     in_type,
   input  logic signed [OperandWidth-1:0] in_an,
   input  logic signed [OperandWidth-1:0] in_ad,
   input  logic signed [OperandWidth-1:0] in_bn,
   input  logic signed [OperandWidth-1:0] in_bd,
   output logic signed [31:0]             res_num,
   output logic [30:0]                    res_den,
   output logic                           cmp_true,
   output logic                           div_error
);

   logic [2:0]                     op_ff;
   logic signed [OperandWidth-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [ProdWidth-1:0]    p1_ff, p2_ff, pd_ff;
   logic [MagWidth-1:0]            nm_ff, dm_ff, u_ff, v_ff, q_ff, r_ff, g_ff;
   logic [CntWidth-1:0]            sh_ff, cnt_ff;
   logic                           nneg_ff, dneg_ff, err_ff, zero_ff;
   logic                           lhs_lt_ff, lhs_eq_ff, flip_ff;

   logic signed [ProdWidth-1:0] m1, m2;
   logic signed [MagWidth-1:0]  s_x, s_y, s_sum;
   logic [MagWidth-1:0]         dmag;
   logic                        arith, ad_z, bd_z;
   logic [MagWidth-1:0]         u_n, v_n, big, small_v;
   logic [MagWidth:0]           trial;
   logic [MagWidth-1:0]         rshift;

   assign arith = (op_ff == OP_ADD) || (op_ff == OP_SUB) ||
                  (op_ff == OP_MUL) || (op_ff == OP_DIV);
   assign ad_z  = (ad_ff == '0);
   assign bd_z  = (bd_ff == '0);

   // Two products per cycle.
   always_comb begin
      m1 = an_ff * ((op_ff == OP_MUL) ? bn_ff : bd_ff);
      m2 = ((op_ff == OP_DIV) ? bn_ff : bd_ff) * ad_ff;
      if (op_ff == OP_ADD || op_ff == OP_SUB || op_ff == OP_LT || op_ff == OP_EQ)
         m2 = bn_ff * ad_ff;
   end

   always_comb begin
      s_x = MagWidth'(p1_ff);
      s_y = (op_ff == OP_ADD) ? MagWidth'(p2_ff) :
            (op_ff == OP_SUB) ? -MagWidth'(p2_ff) : '0;
      s_sum = s_x + s_y;
      dmag = pd_ff[ProdWidth-1] ? MagWidth'(-MagWidth'(pd_ff)) : MagWidth'(pd_ff);
   end

   // Binary GCD step: strip common twos, then subtract.
   always_comb begin
      u_n = u_ff;
      v_n = v_ff;
      big = (u_ff > v_ff) ? u_ff : v_ff;
      small_v = (u_ff > v_ff) ? v_ff : u_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_n = u_ff >> 1;
         v_n = v_ff >> 1;
      end else if (!u_ff[0]) begin
         u_n = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_n = v_ff >> 1;
      end else begin
         u_n = small_v;
         v_n = (big - small_v) >> 1;
      end
   end

   assign rshift = {r_ff[MagWidth-2:0], q_ff[MagWidth-1]};
   assign trial  = {1'b0, rshift} - {1'b0, g_ff};

   assign sts.early    = !arith || ad_z || bd_z || (dmag == '0 && cmd.sum) ||
                         (s_sum == '0 && cmd.sum);
   assign sts.gcd_done = (v_ff == '0) || (u_ff == '0);
   assign sts.div_last = (cnt_ff == CntWidth'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff  <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            op_ff <= in_type;
            an_ff <= in_an;
            ad_ff <= in_ad;
            bn_ff <= in_bn;
            bd_ff <= in_bd;
            err_ff  <= 1'b0;
            zero_ff <= 1'b0;
         end
         if (cmd.prod) begin
            p1_ff <= m1;
            p2_ff <= m2;
            pd_ff <= (op_ff == OP_DIV) ? ProdWidth'(ad_ff * bn_ff) : ProdWidth'(ad_ff * bd_ff);
            flip_ff <= ad_ff[OperandWidth-1] ^ bd_ff[OperandWidth-1];
         end
         if (cmd.sum) begin
            nneg_ff <= s_sum[MagWidth-1];
            nm_ff   <= s_sum[MagWidth-1] ? MagWidth'(-s_sum) : MagWidth'(s_sum);
            dneg_ff <= pd_ff[ProdWidth-1];
            dm_ff   <= dmag;
            u_ff    <= s_sum[MagWidth-1] ? MagWidth'(-s_sum) : MagWidth'(s_sum);
            v_ff    <= dmag;
            sh_ff   <= '0;
            lhs_lt_ff <= p1_ff < p2_ff;
            lhs_eq_ff <= p1_ff == p2_ff;
            // Unused operation codes never flag an error.
            err_ff  <= ((arith || op_ff == OP_LT || op_ff == OP_EQ) && (ad_z || bd_z)) ||
                       (arith && dmag == '0);
            zero_ff <= arith && (s_sum == '0);
         end
         if (cmd.gcd_step) begin
            u_ff <= u_n;
            v_ff <= v_n;
            if (!u_ff[0] && !v_ff[0]) sh_ff <= sh_ff + CntWidth'(1);
         end
         if (cmd.div_start) begin
            g_ff   <= ((u_ff | v_ff) << sh_ff);
            q_ff   <= cmd.div_den ? dm_ff : nm_ff;
            r_ff   <= '0;
            cnt_ff <= CntWidth'(MagWidth);
         end
         if (cmd.div_step) begin
            if (!trial[MagWidth]) begin
               r_ff <= trial[MagWidth-1:0];
               q_ff <= {q_ff[MagWidth-2:0], 1'b1};
            end else begin
               r_ff <= rshift;
               q_ff <= {q_ff[MagWidth-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CntWidth'(1);
            if (cnt_ff == CntWidth'(1) && !cmd.div_den) begin
               nm_ff <= {q_ff[MagWidth-2:0], !trial[MagWidth]};
            end
            if (cnt_ff == CntWidth'(1) && cmd.div_den) begin
               dm_ff <= {q_ff[MagWidth-2:0], !trial[MagWidth]};
            end
         end
      end
   end

   // Output formatting with saturation.
   always_comb begin
      res_num   = '0;
      res_den   = '0;
      cmp_true  = 1'b0;
      div_error = err_ff;
      if (!err_ff) begin
         if (arith) begin
            if (zero_ff) begin
               res_den = 31'd1;
            end else begin
               if (nneg_ff != dneg_ff)
                  res_num = (nm_ff > MagWidth'(33'h80000000)) ? 32'sh80000000 :
                            32'(-nm_ff);
               else
                  res_num = (nm_ff > MagWidth'(33'h7FFFFFFF)) ? 32'sh7FFFFFFF :
                            32'(nm_ff);
               res_den = (dm_ff > MagWidth'(33'h7FFFFFFF)) ? 31'h7FFFFFFF : 31'(dm_ff);
            end
         end else if (op_ff == OP_EQ) begin
            cmp_true = lhs_eq_ff;
         end else if (op_ff == OP_LT) begin
            cmp_true = flip_ff ? (!lhs_lt_ff && !lhs_eq_ff) : lhs_lt_ff;
         end
      end
   end

endmodule

### rtl/rau_ctrl.sv
// Controller state machine sequencing products, GCD and the two divisions.
module rau_ctrl
   import rau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_PROD;
         ST_PROD: state_in = ST_SUM;
         ST_SUM:  state_in = sts.early ? ST_DONE : ST_GCD;
         ST_GCD:  if (sts.gcd_done) state_in = ST_DIVN;
         ST_DIVN: if (sts.div_last) state_in = ST_DIVD;
         ST_DIVD: if (sts.div_last) state_in = ST_DONE;
         ST_DONE: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Each division opens with a setup step, marked by the GCD finishing or the first
   // division finishing.
   always_comb begin
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_PROD: cmd.prod = 1'b1;
         ST_SUM:  cmd.sum  = 1'b1;
         ST_GCD: begin
            cmd.gcd_step  = !sts.gcd_done;
            cmd.div_start = sts.gcd_done;
         end
         ST_DIVN: begin
            cmd.div_step = 1'b1;
         end
         ST_DIVD: begin
            cmd.div_den  = 1'b1;
            cmd.div_step = 1'b1;
         end
         ST_DONE: out_valid = 1'b1;
         default: cmd = '0;
      endcase
      if (state_ff == ST_DIVN && sts.div_last) begin
         cmd.div_start = 1'b0;
      end
   end

   // A second setup at the end of the numerator division: hold g, reload the dividend.
   logic den_setup_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         den_setup_ff <= 1'b0;
      end else begin
         den_setup_ff <= (state_ff == ST_DIVN) && sts.div_last;
      end
   end

   property p_done_holds;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_DONE && !out_ready) |=> (state_ff == ST_DONE);
   endproperty
   assert property (p_done_holds) else $error("result dropped while stalled");

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset)
         (state_ff != ST_IDLE) |-> !in_ready;
   endproperty
   assert property (p_no_accept_busy) else $error("request taken while busy");

   property p_den_follows;
      @(posedge clock) disable iff (reset)
         den_setup_ff |-> (state_ff == ST_DIVD);
   endproperty
   assert property (p_den_follows) else $error("denominator division skipped");

endmodule

### rtl/rational_arith_unit.sv
// Top level of the rational arithmetic unit.
// One request carries an operation and two signed fractions; it yields one result. Comparisons,
// errors and zero results end after the product and sum states; arithmetic then runs the binary
// GCD on the 33-bit magnitudes and two restoring divisions by the GCD, one quotient bit per cycle.
// One request is in flight at a time; the result waits in a register until it is taken.
module rational_arith_unit
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: a_num[15:0], a_den[31:16], b_num[47:32], b_den[63:48]
   input  logic [63:0] req_tdata,
   // tuser: req_type[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: res_num[31:0], res_den[62:32], cmp_true[63], div_error[64], zeros
   output logic [71:0] rsp_tdata
);

   cmd_type cmd;
   sts_type sts;
   logic signed [31:0] res_num;
   logic [30:0]        res_den;
   logic               cmp_true, div_error;

   // The division setup is raised at GCD completion and again between the two divisions.
   // The second setup takes the first cycle of the denominator division, right after the
   // last numerator step.
   cmd_type cmd_dp;
   logic    div_last_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_last_d_ff <= 1'b0;
      end else begin
         div_last_d_ff <= cmd.div_step && !cmd.div_den && sts.div_last;
      end
   end

   always_comb begin
      cmd_dp = cmd;
      if (div_last_d_ff) begin
         cmd_dp.div_start = 1'b1;
         cmd_dp.div_den   = 1'b1;
         cmd_dp.div_step  = 1'b0;
      end
   end

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rau_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_dp),
      .sts       (sts),
      .in_type   (req_tuser),
      .in_an     (req_tdata[15:0]),
      .in_ad     (req_tdata[31:16]),
      .in_bn     (req_tdata[47:32]),
      .in_bd     (req_tdata[63:48]),
      .res_num   (res_num),
      .res_den   (res_den),
      .cmp_true  (cmp_true),
      .div_error (div_error)
   );

   assign rsp_tdata = {7'd0, div_error, cmp_true, res_den, res_num};

   property p_setup_once;
      @(posedge clock) disable iff (reset)
         div_last_d_ff |-> !cmd.div_start;
   endproperty
   assert property (p_setup_once) else $error("double division setup");

   property p_zero_den_err;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && rsp_tdata[64]) |-> (rsp_tdata[62:0] == '0);
   endproperty
   assert property (p_zero_den_err) else $error("error result carries data");

   property p_idle_no_rsp;
      @(posedge clock) disable iff (reset)
         req_tready |-> !rsp_tvalid;
   endproperty
   assert property (p_idle_no_rsp) else $error("result shown while idle");

endmodule

### test/tb_top.sv
// Self-checking testbench for the rational arithmetic unit: random and directed requests.
module tb_top;
   import rau_pkg::*;

   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic               cmp;
      logic               err;
   } rat_result_type;

   // Scoreboard: predicts the result of each accepted request and checks the responses.
   class rat_scoreboard;
      rat_result_type pending[$];
      int             errors;

      function automatic longint unsigned gcd64(longint unsigned p, longint unsigned q);
         longint unsigned r;
         while (q != 0) begin
            r = p % q;
            p = q;
            q = r;
         end
         return p;
      endfunction

      function automatic void note_request(logic [2:0] op, logic signed [15:0] an,
                                           logic signed [15:0] ad, logic signed [15:0] bn,
                                           logic signed [15:0] bd);
         rat_result_type  r;
         longint          nprod, dprod, lhs, rhs;
         longint unsigned nm, dm, g;
         logic            neg;
         r = '{num: '0, den: '0, cmp: 1'b0, err: 1'b0};
         lhs = longint'(an) * longint'(bd);
         rhs = longint'(bn) * longint'(ad);
         if (op <= OP_DIV) begin
            case (op)
               OP_ADD: nprod = lhs + rhs;
               OP_SUB: nprod = lhs - rhs;
               OP_MUL: nprod = longint'(an) * longint'(bn);
               default: nprod = lhs;
            endcase
            dprod = (op == OP_DIV) ? longint'(ad) * longint'(bn)
                                   : longint'(ad) * longint'(bd);
            nm = (nprod < 0) ? -nprod : nprod;
            dm = (dprod < 0) ? -dprod : dprod;
            if (ad == 0 || bd == 0 || dm == 0) begin
               r.err = 1'b1;
            end else if (nm == 0) begin
               r.den = 31'd1;
            end else begin
               g = gcd64(nm, dm);
               neg = (nprod < 0) != (dprod < 0);
               nm = nm / g;
               dm = dm / g;
               // Saturation cannot occur at 16-bit operands but is kept for safety.
               if (neg) begin
                  if (nm > 64'h8000_0000) nm = 64'h8000_0000;
                  r.num = -nm[31:0];
               end else begin
                  if (nm > 64'h7FFF_FFFF) nm = 64'h7FFF_FFFF;
                  r.num = nm[31:0];
               end
               if (dm > 64'h7FFF_FFFF) dm = 64'h7FFF_FFFF;
               r.den = dm[30:0];
            end
         end else if (op == OP_LT || op == OP_EQ) begin
            if (ad == 0 || bd == 0) begin
               r.err = 1'b1;
            end else if (op == OP_EQ) begin
               r.cmp = (lhs == rhs);
            end else begin
               // Opposite denominator signs reverse the cross-product ordering.
               r.cmp = ((ad < 0) != (bd < 0)) ? (lhs > rhs) : (lhs < rhs);
            end
         end
         pending.push_back(r);
      endfunction

      task automatic report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task automatic check_response(logic [71:0] d);
         rat_result_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response %h", d));
            return;
         end
         e = pending.pop_front();
         if (d[31:0] !== e.num)
            report($sformatf("res_num %0d, expected %0d", $signed(d[31:0]), e.num));
         if (d[62:32] !== e.den)
            report($sformatf("res_den %0d, expected %0d", d[62:32], e.den));
         if (d[63] !== e.cmp) report($sformatf("cmp_true %b, expected %b", d[63], e.cmp));
         if (d[64] !== e.err) report($sformatf("div_error %b, expected %b", d[64], e.err));
         if (d[71:65] !== '0) report("padding bits not zero");
      endtask
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic [71:0] rsp_tdata;
   bit          calm;
   rat_scoreboard board;

   rational_arith_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Response side: random stalls, none during the calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         rsp_tready <= calm || ($urandom_range(99) >= 7);
      end
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(6)) - 3);
         4, 5: return 16'($urandom);
         default: return 16'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   // The valid line is dropped once ready is seen and the task then waits on a clock edge, so the
   // next request never assigns the valid line in the same time step.
   task automatic send_request(logic [2:0] op, logic [15:0] an, logic [15:0] ad,
                               logic [15:0] bn, logic [15:0] bd);
      while (!calm && $urandom_range(99) < 7) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {bd, bn, ad, an};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, an, ad, bn, bd);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random();
      logic [15:0] ad, bd;
      ad = pick_value();
      bd = pick_value();
      // Mostly nonzero denominators so that reduction is exercised.
      if (ad == 0 && $urandom_range(3) != 0) ad = 16'd7;
      if (bd == 0 && $urandom_range(3) != 0) bd = 16'hFFFB;
      send_request(3'($urandom_range(7)), pick_value(), ad, pick_value(), bd);
   endtask

   initial begin
      int n;
      board = new();
      calm = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: every operation, extremes, zero denominators, zero results.
      for (int op = 0; op < 8; op++)
         send_request(3'(op), 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_request(OP_ADD, 16'd1, 16'd2, 16'hFFFF, 16'd2);
      send_request(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
      send_request(OP_MUL, 16'd3, 16'd0, 16'd1, 16'd5);
      send_request(OP_LT, 16'd1, 16'd5, 16'd1, 16'd0);
      send_request(OP_LT, 16'd1, 16'hFFFE, 16'd1, 16'd3);
      send_request(OP_EQ, 16'd2, 16'hFFFC, 16'hFFFF, 16'd2);
      send_request(OP_SUB, 16'd6, 16'hFFF7, 16'hFFFE, 16'd3);
      send_request(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
      send_request(OP_DIV, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_ADD, 16'h7FFF, 16'h0001, 16'h7FFF, 16'h0001);
      // Hold off until the unit has drained.
      while (board.pending.size() != 0) @(posedge clock);
      for (n = 0; n < 1100; n++) begin
         calm = (n >= 400 && n < 550);
         send_random();
      end
      calm = 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
